### hw/rtl/ast_pkg.sv
// Shared constants, types and helper functions for the alarm schedule table.
`timescale 1ns / 1ps

package ast_pkg;

    localparam int ENTRIES_PER_LIST = 16;
    localparam int NUM_LISTS        = 3;
    localparam int POS_W            = (ENTRIES_PER_LIST > 1) ? $clog2(ENTRIES_PER_LIST) : 1;
    localparam int CNT_W            = $clog2(ENTRIES_PER_LIST + 1);
    localparam int ADDR_W           = $clog2(NUM_LISTS * ENTRIES_PER_LIST);
    localparam int KEY_W            = 40;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    localparam logic [1:0] KIND_ONCE   = 2'd0;
    localparam logic [1:0] KIND_DAILY  = 2'd1;
    localparam logic [1:0] KIND_WEEKLY = 2'd2;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_DELETED   = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_CLEARED   = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [15:0] duration;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } alarm_entry_t;

    function automatic logic [KEY_W-1:0] time_key(input logic [11:0] y, input logic [3:0] mo,
                                                  input logic [4:0] d, input logic [4:0] h,
                                                  input logic [5:0] mi, input logic [5:0] s);
        return {y, 1'b0, mo, d, 1'b0, h, mi, s};
    endfunction

    function automatic logic [KEY_W-1:0] entry_key(input alarm_entry_t e);
        return time_key(e.year, e.month, e.day, e.hour, e.minute, e.second);
    endfunction

    // Treats 2100 as the only century year that is not leap, which holds for years 2000 to 2127.
    function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] mo);
        logic [4:0] r;
        case (mo)
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            4'd2: r = ((y[1:0] == 2'b00) && (y != 12'd2100)) ? 5'd29 : 5'd28;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] mod7(input logic [4:0] x);
        logic [4:0] t;
        t = (x >= 5'd14) ? x - 5'd14 : x;
        t = (t >= 5'd14) ? t - 5'd14 : t;
        t = (t >= 5'd7) ? t - 5'd7 : t;
        return t[2:0];
    endfunction

endpackage

### hw/rtl/alarm_schedule_table.sv
// Alarm schedule table: three sorted alarm lists held in one synchronous memory.
`timescale 1ns / 1ps

// One command item is taken at a time. An add first steps the alarm date forward one day at a
// time (one week for the weekly list) until it lies after the current time, then walks the
// chosen list from the top, moving each later entry up by one, to open a slot in order. A delete
// scans from the front for a match and closes the gap by moving each later entry down. A clear
// empties all three lists at once. The memory port of the entry store sets the shifting cost;
// the date stepping sets the add cost, which grows with how far in the past the alarm lies.
// The result item sits in an output register until taken.
module alarm_schedule_table
    import ast_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata from bit 0: alarm_year(12) alarm_month(4) alarm_day(5) alarm_hour(5)
    // alarm_minute(6) alarm_second(6) water_duration(16) now_stamp(33), zero pad(1)
    input  logic [87:0] s_tdata,
    // tuser from bit 0: operation(2) repeat_kind(2)
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata from bit 0: stored_year(12) stored_month(4) stored_day(5) list_count(5), pad(6)
    output logic [31:0] m_tdata,
    // tuser from bit 0: status(3)
    output logic [2:0]  m_tuser
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADV   = 4'd1;
    localparam logic [3:0] S_INSRD = 4'd2;
    localparam logic [3:0] S_INSWR = 4'd3;
    localparam logic [3:0] S_DELRD = 4'd4;
    localparam logic [3:0] S_DELWR = 4'd5;
    localparam logic [3:0] S_SHRD  = 4'd6;
    localparam logic [3:0] S_SHWR  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [1:0]        kind_reg, kind_next;
    logic [11:0]       year_reg, year_next;
    logic [3:0]        month_reg, month_next;
    logic [4:0]        day_reg, day_next;
    logic [4:0]        hour_reg, hour_next;
    logic [5:0]        minute_reg, minute_next;
    logic [5:0]        second_reg, second_next;
    logic [15:0]       dur_reg, dur_next;
    logic [KEY_W-1:0]  now_key_reg, now_key_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [2:0]        status_reg, status_next;
    logic [CNT_W-1:0]  len_reg [NUM_LISTS];
    logic [CNT_W-1:0]  len_next [NUM_LISTS];
    logic              out_valid_reg;
    logic [31:0]       out_data_reg;
    logic [2:0]        out_user_reg;

    alarm_entry_t      mem [NUM_LISTS * ENTRIES_PER_LIST];
    alarm_entry_t      rd_data;
    logic              rd_en, wr_en;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    alarm_entry_t      wr_data;

    logic [CNT_W-1:0]  cur_len;
    logic [ADDR_W-1:0] base;
    alarm_entry_t      new_entry;
    logic [KEY_W-1:0]  alarm_key;
    logic [4:0]        mdays;
    logic [5:0]        day_plus7;
    logic [11:0]       in_year;
    logic [3:0]        in_month;
    logic              emit;
    logic              match;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign cur_len   = (kind_reg < 2'd3) ? len_reg[kind_reg] : '0;
    assign base      = ADDR_W'(kind_reg * ENTRIES_PER_LIST);
    assign new_entry = '{duration: dur_reg, second: second_reg, minute: minute_reg,
                         hour: hour_reg, day: day_reg, month: month_reg, year: year_reg};
    assign alarm_key = time_key(year_reg, month_reg, day_reg, hour_reg, minute_reg, second_reg);
    assign mdays     = month_days(year_reg, month_reg);
    assign day_plus7 = {1'b0, day_reg} + 6'd7;
    assign emit      = !out_valid_reg || m_tready;
    assign match     = (rd_data.second == second_reg) && (rd_data.minute == minute_reg) &&
                       (rd_data.hour == hour_reg) &&
                       ((kind_reg == KIND_DAILY) || (mod7(rd_data.day) == mod7(day_reg)));

    // Month and year are brought into range only for the three real lists.
    always_comb
    begin
        in_month = s_tdata[15:12];
        in_year  = s_tdata[11:0];
        if (s_tuser[3:2] < 2'd3)
        begin
            if (in_month == 4'd0)
                in_month = 4'd1;
            else if (in_month > 4'd12)
                in_month = 4'd12;
            if (in_year < 12'd2000)
                in_year = 12'd2000;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        kind_next    = kind_reg;
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        hour_next    = hour_reg;
        minute_next  = minute_reg;
        second_next  = second_reg;
        dur_next     = dur_reg;
        now_key_next = now_key_reg;
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        for (int k = 0; k < NUM_LISTS; k++)
            len_next[k] = len_reg[k];
        rd_en   = 1'b0;
        rd_addr = base;
        wr_en   = 1'b0;
        wr_addr = base;
        wr_data = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next      = s_tuser[1:0];
                    kind_next    = s_tuser[3:2];
                    year_next    = in_year;
                    month_next   = in_month;
                    day_next     = s_tdata[20:16];
                    hour_next    = s_tdata[25:21];
                    minute_next  = s_tdata[31:26];
                    second_next  = s_tdata[37:32];
                    dur_next     = s_tdata[53:38];
                    now_key_next = time_key(12'd2000 + {5'd0, s_tdata[86:80]}, s_tdata[79:76],
                                            s_tdata[75:71], s_tdata[70:66], s_tdata[65:60],
                                            s_tdata[59:54]);
                    status_next  = ST_NOT_FOUND;
                    cnt_next     = '0;
                    unique case (s_tuser[1:0])
                        OP_ADD:
                        begin
                            if (s_tuser[3:2] == 2'd3)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                                state_next = S_ADV;
                        end
                        OP_DELETE:
                            state_next = (s_tuser[3:2] == 2'd3) ? S_DONE : S_DELRD;
                        OP_CLEAR:
                        begin
                            for (int k = 0; k < NUM_LISTS; k++)
                                len_next[k] = '0;
                            status_next = ST_CLEARED;
                            state_next  = S_DONE;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_ADV:
            begin
                if (alarm_key <= now_key_reg)
                begin
                    logic carry;
                    if (kind_reg == KIND_WEEKLY)
                    begin
                        carry    = !(day_plus7 <= {1'b0, mdays});
                        day_next = carry ? 5'(day_plus7 - {1'b0, mdays}) : day_plus7[4:0];
                    end
                    else
                    begin
                        carry    = !(day_reg < mdays);
                        day_next = carry ? 5'd1 : day_reg + 5'd1;
                    end
                    if (carry)
                    begin
                        if (month_reg >= 4'd12)
                        begin
                            month_next = 4'd1;
                            year_next  = year_reg + 12'd1;
                        end
                        else
                            month_next = month_reg + 4'd1;
                    end
                end
                else if (cur_len >= CNT_W'(ENTRIES_PER_LIST))
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    cnt_next   = cur_len;
                    state_next = S_INSRD;
                end
            end
            S_INSRD:
            begin
                // Walk down from the top; cnt is the slot that is free.
                if (cnt_reg == '0)
                begin
                    wr_en              = 1'b1;
                    wr_addr            = base;
                    wr_data            = new_entry;
                    len_next[kind_reg] = cur_len + CNT_W'(1);
                    status_next        = ST_ADDED;
                    state_next         = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = base + ADDR_W'(cnt_reg - CNT_W'(1));
                    state_next = S_INSWR;
                end
            end
            S_INSWR:
            begin
                wr_en   = 1'b1;
                wr_addr = base + ADDR_W'(cnt_reg);
                if (entry_key(rd_data) < alarm_key)
                begin
                    wr_data            = new_entry;
                    len_next[kind_reg] = cur_len + CNT_W'(1);
                    status_next        = ST_ADDED;
                    state_next         = S_DONE;
                end
                else
                begin
                    wr_data    = rd_data;
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = S_INSRD;
                end
            end
            S_DELRD:
            begin
                if (cnt_reg >= cur_len)
                    state_next = S_DONE;
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = base + ADDR_W'(cnt_reg);
                    state_next = S_DELWR;
                end
            end
            S_DELWR:
            begin
                if (match)
                    state_next = S_SHRD;
                else
                begin
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_DELRD;
                end
            end
            S_SHRD:
            begin
                if ((cnt_reg + CNT_W'(1)) >= cur_len)
                begin
                    len_next[kind_reg] = cur_len - CNT_W'(1);
                    status_next        = ST_DELETED;
                    state_next         = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = base + ADDR_W'(cnt_reg + CNT_W'(1));
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                wr_en      = 1'b1;
                wr_addr    = base + ADDR_W'(cnt_reg);
                wr_data    = rd_data;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_SHRD;
            end
            S_DONE:
            begin
                if (emit)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        kind_reg    <= kind_next;
        year_reg    <= year_next;
        month_reg   <= month_next;
        day_reg     <= day_next;
        hour_reg    <= hour_next;
        minute_reg  <= minute_next;
        second_reg  <= second_next;
        dur_reg     <= dur_next;
        now_key_reg <= now_key_next;
        cnt_reg     <= cnt_next;
        status_reg  <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
            for (int k = 0; k < NUM_LISTS; k++)
                len_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            for (int k = 0; k < NUM_LISTS; k++)
                len_reg[k] <= len_next[k];
            if (state_reg == S_DONE && emit)
            begin
                out_valid_reg <= 1'b1;
                out_user_reg  <= status_reg;
                if (op_reg == OP_ADD)
                    out_data_reg <= {6'd0, 5'(cur_len), day_reg, month_reg, year_reg};
                else
                    out_data_reg <= {6'd0, 5'(cur_len), 21'd0};
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // A list never holds more entries than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg[0] <= CNT_W'(ENTRIES_PER_LIST)) && (len_reg[1] <= CNT_W'(ENTRIES_PER_LIST)) &&
        (len_reg[2] <= CNT_W'(ENTRIES_PER_LIST)))
        else $error("list length beyond capacity");

    // The entry store is touched only while a command is being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !(wr_en || rd_en))
        else $error("memory access outside a command");

    // Writes stay within the chosen list.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (kind_reg < 2'd3) && (wr_addr >= base) &&
                  (wr_addr < base + ADDR_W'(ENTRIES_PER_LIST)))
        else $error("write outside the chosen list");

    // A result is produced only on leaving the final state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result without a finished command");

endmodule
